// ----- hw/rtl/ckt_pkg.sv -----
`default_nettype none

package ckt_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_DUPLICATE = 3'd3,
    STATUS_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] key;
    logic [31:0]        entry_data;
    logic [3:0]         position;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [3:0]         slot;
    logic signed [31:0] key_out;
    logic [31:0]        data_out;
    logic [4:0]         entry_count;
  } out_word_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic capture;   // latch the compare result for a new word
    logic occupied;  // cell index is below the fill count
    logic load;      // write the incoming key and payload
    logic shift;     // take the right neighbor's contents
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ckt_cell.sv -----
`default_nettype none

module ckt_cell
  import ckt_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic signed [31:0] cmp_key,
  input  wire logic signed [31:0] load_key,
  input  wire logic [DW-1:0]      load_data,
  input  wire logic signed [31:0] next_key,
  input  wire logic [DW-1:0]      next_data,
  output logic signed [31:0]      key_q,
  output logic [DW-1:0]           data_q,
  output logic                    match_q
);

  logic signed [31:0] key_r, key_nxt;
  logic [DW-1:0]      data_r, data_nxt;
  logic               match_r, match_nxt;

  always_comb begin
    key_nxt   = key_r;
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctrl.load) begin
      key_nxt  = load_key;
      data_nxt = load_data;
    end else if (ctrl.shift) begin
      key_nxt  = next_key;
      data_nxt = next_data;
    end
    if (ctrl.capture) begin
      match_nxt = ctrl.occupied && (key_r == cmp_key);
    end
  end

  // Payload holds without reset; only the match flag is cleared.
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign key_q   = key_r;
  assign data_q  = data_r;
  assign match_q = match_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ckt_pick.sv -----
`default_nettype none

module ckt_pick
  import ckt_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DW    = 32,
  parameter int IW    = 4
) (
  input  wire logic [DEPTH-1:0]   sel,
  input  wire logic signed [31:0] keys [DEPTH],
  input  wire logic [DW-1:0]      datas [DEPTH],
  output logic                    hit,
  output logic [IW-1:0]           hit_idx,
  output logic signed [31:0]      hit_key,
  output logic [DW-1:0]           hit_data
);

  // At most one select bit is set: keys in the table are unique.
  always_comb begin
    hit      = |sel;
    hit_idx  = '0;
    hit_key  = '0;
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_key  = hit_key | keys[i];
        hit_data = hit_data | datas[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/compacting_key_table.sv -----
`default_nettype none

// Channel | Direction | Handshake               | Payload
// in_     | input     | in_valid / in_ready     | in_word_t  (kind, key, entry_data, position)
// out_    | output    | out_valid / out_ready   | out_word_t (status, slot, key_out, data_out,
//         |           |                         |             entry_count)
//
// Each word passes two steps: the accept cycle compares the key against every
// cell, the execute cycle encodes the match and updates the cell row.
// A remove shifts all later cells down by one in that same execute cycle.
// Reset (rst_n low, synchronous) clears the fill count, control and match flags
// only; cell keys and payloads stay undefined until written, no clearing pass is needed.
// A stalled result register holds execute; a new word is taken while the
// previous result still waits.

module compacting_key_table
  import ckt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t    state_r, state_nxt;
  in_word_t  item_r;
  out_word_t out_r, res;
  logic      out_valid_r;
  logic [CW-1:0] count_r, count_nxt;

  logic accept, fire;
  logic ins_ok, rem_ok;

  logic [TABLE_DEPTH-1:0] occ, match, pos_sel, sel, load, shift;
  cell_ctrl_t             ctrl [TABLE_DEPTH];
  logic signed [31:0]     keys [TABLE_DEPTH];
  logic [DATA_WIDTH-1:0]  datas [TABLE_DEPTH];

  logic                    hit;
  logic [IW-1:0]           hit_idx;
  logic signed [31:0]      hit_key;
  logic [DATA_WIDTH-1:0]   hit_data;
  logic [63:0]             ext_in, ext_out;
  logic [31:0]             pos_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // Advance out of execute only when the result register is free.
  assign fire      = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ext_in  = 64'(item_r.entry_data);
  assign ext_out = 64'(hit_data);
  assign pos_w   = 32'(item_r.position);

  // Occupancy and position select, two compares per cell.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ[i]     = CW'(i) < count_r;
      pos_sel[i] = occ[i] && (pos_w == 32'(i));
    end
  end

  assign sel = (item_r.kind == KIND_READ) ? pos_sel : match;

  ckt_pick #(
    .DEPTH (TABLE_DEPTH),
    .DW    (DATA_WIDTH),
    .IW    (IW)
  ) u_pick (
    .sel      (sel),
    .keys     (keys),
    .datas    (datas),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .hit_key  (hit_key),
    .hit_data (hit_data)
  );

  // Sequencer and result formation.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ins_ok    = 1'b0;
    rem_ok    = 1'b0;
    res       = '0;
    res.status = STATUS_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt = ST_IDLE;
          unique case (item_r.kind)
            KIND_INSERT: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                res.status = STATUS_FULL;
              end else if (hit) begin
                res.status = STATUS_DUPLICATE;
              end else begin
                ins_ok    = 1'b1;
                res.slot  = 4'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_REMOVE: begin
              if (!hit) begin
                res.status = STATUS_NOT_FOUND;
              end else begin
                rem_ok    = 1'b1;
                res.slot  = 4'(hit_idx);
                count_nxt = count_r - CW'(1);
              end
            end
            KIND_LOOKUP, KIND_READ: begin
              if (!hit) begin
                res.status = (item_r.kind == KIND_READ) ? STATUS_RANGE : STATUS_NOT_FOUND;
              end else begin
                res.slot     = 4'(hit_idx);
                res.key_out  = hit_key;
                res.data_out = ext_out[31:0];
              end
            end
          endcase
        end
      end
    endcase
    res.entry_count = 5'(count_nxt);
  end

  // Cell row control: append at the fill count, shift down from the hole.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load[i]          = ins_ok && (CW'(i) == count_r);
      shift[i]         = rem_ok && (IW'(i) >= hit_idx);
      ctrl[i].capture  = accept;
      ctrl[i].occupied = occ[i];
      ctrl[i].load     = load[i];
      ctrl[i].shift    = shift[i];
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int NB = (g + 1 < TABLE_DEPTH) ? g + 1 : g;
    ckt_cell #(
      .DW (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[g]),
      .cmp_key   (in_data.key),
      .load_key  (item_r.key),
      .load_data (ext_in[DATA_WIDTH-1:0]),
      .next_key  (keys[NB]),
      .next_data (datas[NB]),
      .key_q     (keys[g]),
      .data_q    (datas[g]),
      .match_q   (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the word and result payloads; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_sel_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(sel))
    else $error("more than one cell selected");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the table");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    rem_ok |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not shrink the table");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC) && !in_ready)
    else $error("accepted word did not enter execute");

endmodule

`default_nettype wire
